// ----- design/msh_pkg.sv -----
// Package: shared types, constants and mode codes for the multi-mode string hash.
`default_nettype none
package msh_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OUT_W = 31;
	localparam int unsigned MODE_W = 3;

	localparam logic [HASH_W-1:0] RS_MULT_INIT = 32'd63689;
	localparam logic [HASH_W-1:0] RS_MULT_STEP = 32'd378551;
	localparam logic [HASH_W-1:0] JS_INIT = 32'd1315423911;
	localparam logic [HASH_W-1:0] BKDR_SEED = 32'd131;
	localparam logic [HASH_W-1:0] DJB_INIT = 32'd5381;
	localparam logic [HASH_W-1:0] TOP_NIBBLE = 32'hF000_0000;
	localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_SDBM = 3'd0,
		MODE_RS   = 3'd1,
		MODE_JS   = 3'd2,
		MODE_PJW  = 3'd3,
		MODE_ELF  = 3'd4,
		MODE_BKDR = 3'd5,
		MODE_DJB  = 3'd6,
		MODE_AP   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_present;
		logic              last_item;
	} item_t;

	function automatic logic [HASH_W-1:0] initial_value(input mode_t mode);
		logic [HASH_W-1:0] v;
		case (mode)
			MODE_JS:  v = JS_INIT;
			MODE_DJB: v = DJB_INIT;
			default:  v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- design/msh_in_stage.sv -----
// Input register stage: captures one word per cycle and holds it while downstream is blocked.
`default_nettype none
module msh_in_stage
	import msh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire item_t in_item,
	output logic      valid_s1,
	output item_t     item_s1,
	input  wire logic advance
);

	logic full_s1;

	assign valid_s1 = full_s1;
	assign in_stall = full_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_s1 <= 1'b0;
		end else if (!in_stall) begin
			full_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ----- design/msh_fold.sv -----
// Combinational fold of one byte into the hash accumulator for the selected mode.
`default_nettype none
module msh_fold
	import msh_pkg::*;
(
	input  wire mode_t             mode,
	input  wire logic [HASH_W-1:0] h,
	input  wire logic [BYTE_W-1:0] c,
	input  wire logic [HASH_W-1:0] rs_mult,
	input  wire logic              parity,
	output logic [HASH_W-1:0]      h_next
);

	logic [HASH_W-1:0] cx;
	logic [HASH_W-1:0] elf_t;
	logic [HASH_W-1:0] elf_top;

	assign cx = {{(HASH_W-BYTE_W){1'b0}}, c};
	assign elf_t = (h << 4) + cx;
	assign elf_top = elf_t & TOP_NIBBLE;

	always_comb begin
		case (mode)
			MODE_SDBM: h_next = cx + (h << 6) + (h << 16) - h;
			MODE_RS:   h_next = h * rs_mult + cx;
			MODE_JS:   h_next = h ^ ((h << 5) + cx + (h >> 2));
			MODE_PJW, MODE_ELF: begin
				if (elf_top != '0) begin
					h_next = (elf_t ^ (elf_top >> 24)) & ~TOP_NIBBLE;
				end else begin
					h_next = elf_t;
				end
			end
			MODE_BKDR: h_next = h * BKDR_SEED + cx;
			MODE_DJB:  h_next = h + (h << 5) + cx;
			MODE_AP: begin
				if (!parity) begin
					h_next = h ^ ((h << 7) ^ cx ^ (h >> 3));
				end else begin
					h_next = h ^ ~((h << 11) ^ cx ^ (h >> 5));
				end
			end
			default:   h_next = h;
		endcase
	end

endmodule
`default_nettype wire

// ----- design/multi_mode_string_hash.sv -----
// Top level: multi-mode string hash with input stage, fold logic and result register.
// Usage:
//   Input channel (in_valid / in_stall) carries one word per cycle: data_byte,
//   byte_present and last_item, while in_stall is low. A word with last_item closes the message.
//   Output channel (out_valid / out_stall) carries hash_value, the low 31
//   bits of the 32-bit accumulator, once per closed message.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes hash_mode; it is
//   always ready and is to be written only while no message is in flight.
//   Throughput: one word per cycle while not stalled, set by the fold
//   recurrence between the input register and the accumulator.
//   A closing word passes through the input register, then the result
//   register, before its result appears on the output channel.
//   When the receiver stalls, the result register holds; words without
//   last_item keep flowing, and a closing word waits in the input register.
//   Reset clears the mode to SDBM, the accumulator to zero, the RS multiplier
//   to 63689 and marks no message open.
`default_nettype none
module multi_mode_string_hash
	import msh_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              byte_present,
	input  wire logic              last_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [OUT_W-1:0]       hash_value,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [MODE_W-1:0] cfg_data
);

	item_t             in_item;
	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	logic              out_free;
	mode_t             mode_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] rs_q;
	logic              parity_q;
	logic              open_q;
	logic [HASH_W-1:0] h_cur;
	logic [HASH_W-1:0] rs_cur;
	logic              par_cur;
	logic [HASH_W-1:0] h_fold;
	logic [HASH_W-1:0] h_new;
	logic              out_valid_q;
	logic [OUT_W-1:0]  hash_q;

	assign in_item = '{data_byte: data_byte, byte_present: byte_present, last_item: last_item};
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!item_s1.last_item || out_free);
	assign out_valid = out_valid_q;
	assign hash_value = hash_q;

	msh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance)
	);

	// message start picks up the mode's initial values
	assign h_cur = open_q ? acc_q : initial_value(mode_q);
	assign rs_cur = open_q ? rs_q : RS_MULT_INIT;
	assign par_cur = open_q ? parity_q : 1'b0;

	msh_fold u_fold (
		.mode    (mode_q),
		.h       (h_cur),
		.c       (item_s1.data_byte),
		.rs_mult (rs_cur),
		.parity  (par_cur),
		.h_next  (h_fold)
	);

	assign h_new = item_s1.byte_present ? h_fold : h_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mode_t'(MODE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			rs_q        <= RS_MULT_INIT;
			parity_q    <= 1'b0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				acc_q <= h_new;
				if (item_s1.byte_present) begin
					rs_q     <= rs_cur * RS_MULT_STEP;
					parity_q <= !par_cur;
				end else begin
					rs_q     <= rs_cur;
					parity_q <= par_cur;
				end
				open_q <= !item_s1.last_item;
				if (item_s1.last_item) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_item) begin
			hash_q <= h_new[OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire
